// File: src/msv_pkg.sv
package msv_pkg;

  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] MAX_LENGTH = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_ASCII  = 2'd0,
    MODE_UTF8   = 2'd1,
    MODE_LATIN1 = 2'd2
  } mode_t;

  localparam logic [7:0] LEAD_MIN    = 8'hC2;
  localparam logic [7:0] LEAD_MAX    = 8'hF4;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] E0_LO       = 8'hA0;
  localparam logic [7:0] ED_HI       = 8'h9F;
  localparam logic [7:0] F0_LO       = 8'h90;
  localparam logic [7:0] F4_HI       = 8'h8F;
  localparam logic [7:0] MASK_2BYTE  = 8'he0;
  localparam logic [7:0] MATCH_2BYTE = 8'hc0;
  localparam logic [7:0] MASK_3BYTE  = 8'hf0;
  localparam logic [7:0] MATCH_3BYTE = 8'he0;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [2:0]        pending;
    logic [1:0]        remain;
    logic [7:0]        lead;
    logic              second;
    logic              failed;
  } str_state_t;

endpackage

// File: src/msv_step.sv
module msv_step (
  input  msv_pkg::str_state_t st,
  input  logic [1:0]          mode,
  input  logic [7:0]          data_byte,
  output msv_pkg::str_state_t st_next
);
  import msv_pkg::*;

  logic [2:0]        add_n;
  logic              do_add;
  logic [CountW:0]   sum;
  logic [7:0]        lo;
  logic [7:0]        hi;
  logic [1:0]        remain_dec;
  logic [2:0]        pending_inc;
  str_state_t        nx;

  assign remain_dec  = st.remain - 2'd1;
  assign pending_inc = st.pending + 3'd1;
  assign sum = {1'b0, st.count} + (CountW+1)'(add_n);

  always_comb begin
    lo = CONT_MIN;
    hi = CONT_MAX;
    if (st.second) begin
      if (st.lead == LEAD_E0) lo = E0_LO;
      else if (st.lead == LEAD_ED) hi = ED_HI;
      else if (st.lead == LEAD_F0) lo = F0_LO;
      else if (st.lead == LEAD_F4) hi = F4_HI;
    end
  end

  always_comb begin
    nx     = st;
    do_add = 1'b0;
    add_n  = 3'd1;
    if (!st.failed) begin
      if (mode == MODE_UTF8) begin
        if (st.remain == 2'd0) begin
          if (data_byte == 8'd0) begin
            nx.failed = 1'b1;
          end else if (!data_byte[7]) begin
            do_add = 1'b1;
          end else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX) begin
            nx.failed = 1'b1;
          end else begin
            if ((data_byte & MASK_2BYTE) == MATCH_2BYTE) nx.remain = 2'd1;
            else if ((data_byte & MASK_3BYTE) == MATCH_3BYTE) nx.remain = 2'd2;
            else nx.remain = 2'd3;
            nx.lead    = data_byte;
            nx.pending = 3'd1;
            nx.second  = 1'b1;
          end
        end else if (data_byte < lo || data_byte > hi) begin
          nx.failed = 1'b1;
        end else begin
          nx.second  = 1'b0;
          nx.remain  = remain_dec;
          nx.pending = pending_inc;
          if (remain_dec == 2'd0) begin
            // character complete: commit all its bytes
            do_add     = 1'b1;
            add_n      = pending_inc;
            nx.pending = 3'd0;
          end
        end
      end else begin
        if (data_byte == 8'd0) nx.failed = 1'b1;
        else do_add = 1'b1;
      end
    end
    if (do_add) begin
      nx.count = (sum >= {1'b0, MAX_LENGTH}) ? MAX_LENGTH : sum[CountW-1:0];
    end
    st_next = nx;
  end

endmodule

// File: src/multibyte_string_validator_unit.sv
// A final byte waits in the input word register while an unread result is held, then
// its result is registered. Throughput: one byte per cycle otherwise; the per-byte state
// update is one short logic level between the input word register and the string state /
// result registers. Reset (rst, synchronous, active high): mode 0 (ASCII), string state
// cleared, both stages empty. A config write also clears the string state.
module multibyte_string_validator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // encoding_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] valid_length
  output logic        m_axis_tuser   // [0] all_valid
);
  import msv_pkg::*;

  logic [1:0] enc_mode;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  str_state_t st;
  str_state_t st_next;
  logic       out_valid;
  logic [CountW-1:0] out_len;
  logic       out_all;

  msv_step u_step (
    .st        (st),
    .mode      (enc_mode),
    .data_byte (in_byte),
    .st_next   (st_next)
  );

  // non-final words never wait on the output register
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_mode  <= MODE_ASCII;
      st        <= '0;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enc_mode <= cfg_wr_data;
        st       <= '0;
      end else if (advance) begin
        st <= in_last ? '0 : st_next;
      end
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance && in_last) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance && in_last) begin
      out_len <= st_next.count;
      out_all <= !st_next.failed && (st_next.remain == 2'd0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_len;
  assign m_axis_tuser  = out_all;

endmodule

// File: src/msv_checker.sv
module msv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a fully valid string has at least one byte counted
  a_valid_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata != 16'd0))
    else $error("all_valid with zero length");

  // input valid low now and in its $past sample, and nothing pending: no result can appear
  a_drain: assert property (@(posedge clk) disable iff (rst)
    ($past(!s_axis_tvalid) && !s_axis_tvalid && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result appeared without input");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind multibyte_string_validator_unit msv_checker u_msv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
